### src/scb_pkg.sv
// Shared types, codes and color tables for the SMPTE color-bar pattern generator.
package scb_pkg;

  // Width of the configuration fields as written on the register port
  localparam int unsigned FIELD_W = 15;
  localparam int unsigned FMT_W   = 4;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned PIX_W   = 32;

  // Reciprocals for exact floor division by 7 and by 3 over coordinate-sized values
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP7      = 149797;
  localparam int unsigned RECIP3      = 349526;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } reg_idx_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_IDX8     = 4'd0,
    FMT_RGB555   = 4'd1,
    FMT_RGB565   = 4'd2,
    FMT_BGR565   = 4'd3,
    FMT_RGB888   = 4'd4,
    FMT_RGBA8888 = 4'd5,
    FMT_RGBX888  = 4'd6,
    FMT_BGR555   = 4'd7,
    FMT_ARGB4444 = 4'd8
  } pix_fmt_e;

  typedef enum logic [1:0] {
    ZONE_TOP = 2'd0,
    ZONE_MID = 2'd1,
    ZONE_BOT = 2'd2
  } zone_e;

  localparam logic [IDX_W-1:0] CI_GREY40    = 4'd1;
  localparam logic [IDX_W-1:0] CI_WHITE75   = 4'd2;
  localparam logic [IDX_W-1:0] CI_YELLOW    = 4'd3;
  localparam logic [IDX_W-1:0] CI_CYAN      = 4'd4;
  localparam logic [IDX_W-1:0] CI_GREEN     = 4'd5;
  localparam logic [IDX_W-1:0] CI_MAGENTA   = 4'd6;
  localparam logic [IDX_W-1:0] CI_RED       = 4'd7;
  localparam logic [IDX_W-1:0] CI_BLUE      = 4'd8;
  localparam logic [IDX_W-1:0] CI_BLACK     = 4'd9;
  localparam logic [IDX_W-1:0] CI_WHITE100  = 4'd10;
  localparam logic [IDX_W-1:0] CI_POS_Q     = 4'd11;
  localparam logic [IDX_W-1:0] CI_POS_I     = 4'd12;
  localparam logic [IDX_W-1:0] CI_NEG_I     = 4'd13;
  localparam logic [IDX_W-1:0] CI_SUPER_BLK = 4'd14;
  localparam logic [IDX_W-1:0] CI_LIGHT_BLK = 4'd15;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t palette(input logic [IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      CI_GREY40:    c = '{8'h68, 8'h68, 8'h68};
      CI_WHITE75:   c = '{8'hB4, 8'hB4, 8'hB4};
      CI_YELLOW:    c = '{8'hB4, 8'hB4, 8'h10};
      CI_CYAN:      c = '{8'h10, 8'hB4, 8'hB4};
      CI_GREEN:     c = '{8'h10, 8'hB4, 8'h10};
      CI_MAGENTA:   c = '{8'hB4, 8'h10, 8'hB4};
      CI_RED:       c = '{8'hB4, 8'h10, 8'h10};
      CI_BLUE:      c = '{8'h10, 8'h10, 8'hB4};
      CI_BLACK:     c = '{8'h10, 8'h10, 8'h10};
      CI_WHITE100:  c = '{8'hEB, 8'hEB, 8'hEB};
      CI_POS_Q:     c = '{8'h48, 8'h10, 8'h76};
      CI_POS_I:     c = '{8'h6A, 8'h34, 8'h10};
      CI_NEG_I:     c = '{8'h10, 8'h46, 8'h6A};
      CI_SUPER_BLK: c = '{8'h09, 8'h09, 8'h09};
      CI_LIGHT_BLK: c = '{8'h1D, 8'h1D, 8'h1D};
      default:      c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

  // Seven 75% bars, left to right
  function automatic logic [IDX_W-1:0] top_bar(input logic [2:0] k);
    logic [IDX_W-1:0] c;
    case (k)
      3'd0:    c = CI_WHITE75;
      3'd1:    c = CI_YELLOW;
      3'd2:    c = CI_CYAN;
      3'd3:    c = CI_GREEN;
      3'd4:    c = CI_MAGENTA;
      3'd5:    c = CI_RED;
      default: c = CI_BLUE;
    endcase
    return c;
  endfunction

  // Reverse bars under the main bars
  function automatic logic [IDX_W-1:0] mid_bar(input logic [2:0] k);
    logic [IDX_W-1:0] c;
    case (k)
      3'd0:    c = CI_BLUE;
      3'd1:    c = CI_BLACK;
      3'd2:    c = CI_MAGENTA;
      3'd3:    c = CI_BLACK;
      3'd4:    c = CI_CYAN;
      3'd5:    c = CI_BLACK;
      default: c = CI_GREY40;
    endcase
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] castle_sq(input logic [1:0] k);
    logic [IDX_W-1:0] c;
    case (k)
      2'd0:    c = CI_NEG_I;
      2'd1:    c = CI_WHITE100;
      2'd2:    c = CI_POS_Q;
      default: c = CI_BLACK;
    endcase
    return c;
  endfunction

endpackage

### src/scb_pix_if.sv
// Valid/ready channel interfaces for pixel coordinate requests and color results.
interface scb_pix_in_if #(
  parameter int unsigned COORD_BITS = 15
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface scb_pix_out_if ();
  logic        valid;
  logic        ready;
  logic [3:0]  colour_index;
  logic [31:0] pixel_value;

  modport source (output valid, output colour_index, output pixel_value, input ready);
  modport sink (input valid, input colour_index, input pixel_value, output ready);
endinterface

### src/smpte_colour_bar_pattern_top.sv
// SMPTE color-bar pattern generator: pixel coordinate in, bar color index and packed pixel out.
//
// Usage: write frame_width (0x0), frame_height (0x4) and pixel_format (0x8) over the APB
// port while no request is in flight, then send pixel coordinates on pix_i. Each request
// yields one result on col_o: the color index and the color packed for the format.
// Throughput: one pixel per clock while col_o.ready holds high; the datapath is a
// four-register pipeline (input, row zone, color index, packed output) and every stage
// advances as soon as the stage after it is empty or moving.
// Bar boundaries are derived from the frame size by two register levels that follow the
// configuration registers; after a write they settle before any request written after
// that write can reach them.
// Reset: the pipeline empties, and the registers return to 640 x 480, rgba8888.
// Stall: when col_o.ready is low the result holds; requests keep entering until the
// pipeline is full, then pix_i.ready drops.
module smpte_colour_bar_pattern_top import scb_pkg::*; #(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  scb_pix_in_if.sink          pix_i,
  scb_pix_out_if.source       col_o
);

  localparam int unsigned PROD_W = COORD_BITS + RECIP_W + 1;
  localparam int unsigned EXT_W  = COORD_BITS + 3;

  // ---------------- configuration registers ----------------
  logic [COORD_BITS-1:0] width_q, height_q;
  logic [FMT_W-1:0]      fmt_q;
  logic                  wr_en;
  reg_idx_e              wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= COORD_BITS'(RESET_WIDTH);
      height_q <= COORD_BITS'(RESET_HEIGHT);
      fmt_q    <= FMT_RGBA8888;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_FRAME_WIDTH:  width_q  <= COORD_BITS'(pwdata[FIELD_W-1:0]);
        REG_FRAME_HEIGHT: height_q <= COORD_BITS'(pwdata[FIELD_W-1:0]);
        REG_PIXEL_FORMAT: fmt_q    <= pwdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
      REG_PIXEL_FORMAT: prdata = PDATA_W'(fmt_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- derived geometry, level 1: bar width and row splits ----------------
  logic [COORD_BITS-1:0] bw_q, h1_q, h2_q;
  logic [COORD_BITS-1:0] bw_d, h1_d, h2_d;
  logic [PROD_W-1:0]     w_prod, h1_prod, h2_prod;

  always_comb begin
    w_prod  = PROD_W'(width_q) * PROD_W'(RECIP7);
    h1_prod = PROD_W'({height_q, 1'b0}) * PROD_W'(RECIP3);
    h2_prod = PROD_W'(height_q >> 2) * PROD_W'(RECIP3);
    bw_d    = COORD_BITS'(w_prod >> RECIP_SHIFT);
    h1_d    = COORD_BITS'(h1_prod >> RECIP_SHIFT);
    h2_d    = COORD_BITS'(h2_prod >> RECIP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    bw_q <= bw_d;
    h1_q <= h1_d;
    h2_q <= h2_d;
  end

  // ---------------- derived geometry, level 2: column boundaries ----------------
  logic [COORD_BITS-1:0] bw2_q, bw3_q, bw4_q, bw5_q, bw6_q, t_q, t2_q, cw_q, cw2_q, cw3_q;
  logic [COORD_BITS-1:0] bw2_d, bw3_d, bw4_d, bw5_d, bw6_d, t_d, t2_d, cw_d, cw2_d, cw3_d;
  logic [EXT_W-1:0]      bw_x, bw5_x, cw_x, t_x;
  logic [PROD_W-1:0]     t_prod;

  always_comb begin
    bw_x   = EXT_W'(bw_q);
    bw5_x  = bw_x + (bw_x << 2);
    cw_x   = bw5_x >> 2;
    t_prod = PROD_W'(bw_q) * PROD_W'(RECIP3);
    t_x    = EXT_W'(t_prod >> RECIP_SHIFT);
    bw2_d  = COORD_BITS'(bw_x << 1);
    bw3_d  = COORD_BITS'(bw_x + (bw_x << 1));
    bw4_d  = COORD_BITS'(bw_x << 2);
    bw5_d  = COORD_BITS'(bw5_x);
    bw6_d  = COORD_BITS'((bw_x << 1) + (bw_x << 2));
    t_d    = COORD_BITS'(t_x);
    t2_d   = COORD_BITS'(t_x << 1);
    cw_d   = COORD_BITS'(cw_x);
    cw2_d  = COORD_BITS'(cw_x << 1);
    cw3_d  = COORD_BITS'(cw_x + (cw_x << 1));
  end

  always_ff @(posedge clk_i) begin
    bw2_q <= bw2_d;
    bw3_q <= bw3_d;
    bw4_q <= bw4_d;
    bw5_q <= bw5_d;
    bw6_q <= bw6_d;
    t_q   <= t_d;
    t2_q  <= t2_d;
    cw_q  <= cw_d;
    cw2_q <= cw2_d;
    cw3_q <= cw3_d;
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || col_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign pix_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [COORD_BITS-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      x1_q <= pix_i.pixel_x;
      y1_q <= pix_i.pixel_y;
    end
  end

  // ---------------- stage 2: row zone ----------------
  logic [COORD_BITS-1:0] x2_q;
  zone_e                 zone2_q, zone2_d;
  logic [COORD_BITS:0]   h12;

  always_comb begin
    h12 = {1'b0, h1_q} + {1'b0, h2_q};
    if (y1_q < h1_q) begin
      zone2_d = ZONE_TOP;
    end else if ({1'b0, y1_q} < h12) begin
      zone2_d = ZONE_MID;
    end else begin
      zone2_d = ZONE_BOT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      x2_q    <= x1_q;
      zone2_q <= zone2_d;
    end
  end

  // ---------------- stage 3: color index ----------------
  logic [IDX_W-1:0]      idx3_q, idx3_d;
  logic [4:0]            bar_ge;
  logic [2:0]            bar_k;
  logic [2:0]            cas_ge;
  logic [1:0]            cas_k;
  logic [COORD_BITS-1:0] off;

  always_comb begin
    bar_ge = {x2_q >= bw5_q, x2_q >= bw4_q, x2_q >= bw3_q, x2_q >= bw2_q, x2_q >= bw_q};
    bar_k  = (x2_q >= bw6_q) ? 3'd6 : 3'($countones(bar_ge));
    // a zero square width makes every compare true, which lands on the last square
    cas_ge = {x2_q >= cw3_q, x2_q >= cw2_q, x2_q >= cw_q};
    cas_k  = 2'($countones(cas_ge));
    off    = x2_q - bw5_q;
    case (zone2_q)
      ZONE_TOP: idx3_d = top_bar(bar_k);
      ZONE_MID: idx3_d = mid_bar(bar_k);
      default: begin
        if (x2_q >= bw6_q) begin
          idx3_d = CI_BLACK;
        end else if (x2_q >= bw5_q) begin
          if (off < t_q) begin
            idx3_d = CI_SUPER_BLK;
          end else if (off < t2_q) begin
            idx3_d = CI_BLACK;
          end else begin
            idx3_d = CI_LIGHT_BLK;
          end
        end else begin
          idx3_d = castle_sq(cas_k);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) idx3_q <= idx3_d;
  end

  // ---------------- stage 4: pack for the pixel format ----------------
  logic [IDX_W-1:0] idx4_q;
  logic [PIX_W-1:0] pix4_q, pix4_d;
  rgb_t             rgb, rgb_ord;

  always_comb begin
    rgb     = palette(idx3_q);
    rgb_ord = rgb;
    // swap red and blue for the BGR layouts
    if (fmt_q == FMT_BGR565 || fmt_q == FMT_BGR555) begin
      rgb_ord.r = rgb.b;
      rgb_ord.b = rgb.r;
    end
    unique case (fmt_q)
      FMT_IDX8:
        pix4_d = PIX_W'(idx3_q);
      FMT_RGB555, FMT_BGR555:
        pix4_d = PIX_W'({rgb_ord.r[7:3], rgb_ord.g[7:3], rgb_ord.b[7:3]});
      FMT_RGB565, FMT_BGR565:
        pix4_d = PIX_W'({rgb_ord.r[7:3], rgb_ord.g[7:2], rgb_ord.b[7:3]});
      FMT_RGB888, FMT_RGBX888:
        pix4_d = {8'h00, rgb_ord.r, rgb_ord.g, rgb_ord.b};
      FMT_RGBA8888:
        pix4_d = {8'hFF, rgb_ord.r, rgb_ord.g, rgb_ord.b};
      FMT_ARGB4444:
        pix4_d = PIX_W'({4'hF, rgb_ord.r[7:4], rgb_ord.g[7:4], rgb_ord.b[7:4]});
      default:
        pix4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      idx4_q <= idx3_q;
      pix4_q <= pix4_d;
    end
  end

  assign col_o.valid        = v4_q;
  assign col_o.colour_index = idx4_q;
  assign col_o.pixel_value  = pix4_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the SMPTE color-bar pattern generator.
`timescale 1ns / 100ps

module testbench;
  import scb_pkg::*;

  localparam int unsigned COORD_BITS    = 15;
  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] colour_index;
    logic [PIX_W-1:0] pixel_value;
  } pixel_result_t;

  // Bar tables, entry 0 on the left
  localparam logic [6:0][IDX_W-1:0] TOP_ROW = {CI_BLUE, CI_RED, CI_MAGENTA, CI_GREEN,
                                               CI_CYAN, CI_YELLOW, CI_WHITE75};
  localparam logic [6:0][IDX_W-1:0] MID_ROW = {CI_GREY40, CI_BLACK, CI_CYAN, CI_BLACK,
                                               CI_MAGENTA, CI_BLACK, CI_BLUE};
  localparam logic [3:0][IDX_W-1:0] CASTLE  = {CI_BLACK, CI_POS_Q, CI_WHITE100, CI_NEG_I};
  // 8-bit R, G, B per color index, entry 15 first
  localparam logic [15:0][23:0] PALETTE = {
    24'h1D1D1D, 24'h090909, 24'h10466A, 24'h6A3410, 24'h481076, 24'hEBEBEB,
    24'h101010, 24'h1010B4, 24'hB41010, 24'hB410B4, 24'h10B410, 24'h10B4B4,
    24'hB4B410, 24'hB4B4B4, 24'h686868, 24'h000000};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  scb_pix_in_if #(.COORD_BITS(COORD_BITS)) coord_ch ();
  scb_pix_out_if colour_ch ();

  smpte_colour_bar_pattern_top #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (coord_ch),
    .col_o   (colour_ch)
  );

  // Shadow of the configuration registers
  logic [FIELD_W-1:0] cfg_width;
  logic [FIELD_W-1:0] cfg_height;
  logic [FMT_W-1:0]   cfg_format;

  pixel_result_t pending_pixels[$];
  int unsigned   requests_sent;
  int unsigned   results_checked;
  int unsigned   settings_written;
  int unsigned   failures;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_reqs;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [IDX_W-1:0] bar_colour_at(input logic [14:0] x,
                                                     input logic [14:0] y);
    int unsigned bw, h1, h2, t, off, cw, k;
    bw = cfg_width / 7;
    h1 = (2 * cfg_height) / 3;
    h2 = cfg_height / 12;
    if (y < h1 + h2) begin
      if (x >= 6 * bw || bw == 0) return (y < h1) ? TOP_ROW[6] : MID_ROW[6];
      k = x / bw;
      return (y < h1) ? TOP_ROW[k] : MID_ROW[k];
    end
    if (x >= 6 * bw) return CI_BLACK;
    if (x >= 5 * bw) begin
      t   = bw / 3;
      off = x - 5 * bw;
      if (off < t) return CI_SUPER_BLK;
      if (off < 2 * t) return CI_BLACK;
      return CI_LIGHT_BLK;
    end
    cw = (bw * 5) / 4;
    k  = (cw == 0) ? 3 : x / cw;
    if (k > 3) k = 3;
    return CASTLE[k];
  endfunction

  function automatic logic [PIX_W-1:0] pack_pixel(input logic [IDX_W-1:0] ci,
                                                  input logic [FMT_W-1:0] fmt);
    logic [7:0] r, g, b, t;
    {r, g, b} = PALETTE[ci];
    if (fmt == FMT_BGR565 || fmt == FMT_BGR555) begin
      t = r;
      r = b;
      b = t;
    end
    case (fmt)
      FMT_IDX8:                 return {28'd0, ci};
      FMT_RGB555, FMT_BGR555:   return {17'd0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565, FMT_BGR565:   return {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB888, FMT_RGBX888:  return {8'd0, r, g, b};
      FMT_RGBA8888:             return {8'hFF, r, g, b};
      FMT_ARGB4444:             return {16'd0, 4'hF, r[7:4], g[7:4], b[7:4]};
      default:                  return '0;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    colour_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        colour_ch.ready <= 1'b0;
      end else begin
        colour_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni === 1'b1 && colour_ch.valid && colour_ch.ready) begin
      results_checked++;
      if (pending_pixels.size() == 0) begin
        $error("result with no request pending: colour_index %0d, pixel_value 0x%08h",
               colour_ch.colour_index, colour_ch.pixel_value);
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        if (colour_ch.colour_index !== want.colour_index) begin
          $error("colour_index: expected %0d, got %0d", want.colour_index,
                 colour_ch.colour_index);
          failures++;
        end
        if (colour_ch.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected 0x%08h, got 0x%08h", want.pixel_value,
                 colour_ch.pixel_value);
          failures++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task automatic send_pixel(input logic [14:0] x, input logic [14:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      coord_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.pixel_x <= x;
    coord_ch.pixel_y <= y;
    do @(posedge clk_i); while (!coord_ch.ready);
    // Leave valid high: the next request may follow back to back
    pending_pixels.push_back('{bar_colour_at(x, y), pack_pixel(bar_colour_at(x, y),
                                                               cfg_format)});
    requests_sent++;
  endtask

  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    coord_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = data[FIELD_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = data[FIELD_W-1:0];
      default:          cfg_format = data[FMT_W-1:0];
    endcase
    settings_written++;
    @(posedge clk_i);
  endtask

  task automatic check_register(input reg_idx_e idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("%s readback: expected 0x%08h, got 0x%08h", idx.name(), want, got);
      failures++;
    end
    @(posedge clk_i);
  endtask

  // Coordinates: mostly inside the frame, some at bar borders, some anywhere
  task automatic send_random_pixel();
    int unsigned bw, cw, t, sel, bx, by;
    logic [14:0] x, y;
    bw  = cfg_width / 7;
    cw  = (bw * 5) / 4;
    t   = bw / 3;
    sel = $urandom_range(99);
    if (sel < 60) begin
      x = 15'($urandom_range(cfg_width - 1, 0));
      y = 15'($urandom_range(cfg_height - 1, 0));
    end else if (sel < 85) begin
      case ($urandom_range(5))
        0:       bx = bw * $urandom_range(7);
        1:       bx = cw * $urandom_range(4);
        2:       bx = 5 * bw + t;
        3:       bx = 5 * bw + 2 * t;
        4:       bx = 6 * bw;
        default: bx = cfg_width;
      endcase
      case ($urandom_range(3))
        0:       by = (2 * cfg_height) / 3;
        1:       by = (2 * cfg_height) / 3 + cfg_height / 12;
        2:       by = $urandom_range(cfg_height - 1, 0);
        default: by = cfg_height;
      endcase
      x = 15'(bx + $urandom_range(2) - 1);
      y = 15'(by + $urandom_range(2) - 1);
    end else begin
      x = 15'($urandom());
      y = 15'($urandom());
    end
    send_pixel(x, y);
  endtask

  task automatic run_setting(input logic [PDATA_W-1:0] w, input logic [PDATA_W-1:0] h,
                             input logic [PDATA_W-1:0] fmt, input int unsigned n);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_PIXEL_FORMAT, fmt);
    check_register(REG_FRAME_WIDTH, {17'd0, cfg_width});
    check_register(REG_FRAME_HEIGHT, {17'd0, cfg_height});
    check_register(REG_PIXEL_FORMAT, {28'd0, cfg_format});
    repeat (n) send_random_pixel();
    wait_for_results();
  endtask

  function automatic logic [FIELD_W-1:0] random_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 15'($urandom_range(200, 1));
      5, 6, 7:       return 15'($urandom_range(2000, 1));
      default:       return 15'($urandom_range(32767, 1));
    endcase
  endfunction

  // Every region of the chart at the reset frame size
  task automatic test_reset_layout();
    int unsigned bw, h1, h2, cw, t, yb;
    set_idling(0, 0);
    check_register(REG_FRAME_WIDTH, RESET_WIDTH);
    check_register(REG_FRAME_HEIGHT, RESET_HEIGHT);
    check_register(REG_PIXEL_FORMAT, {28'd0, FMT_RGBA8888});
    bw = cfg_width / 7;
    h1 = (2 * cfg_height) / 3;
    h2 = cfg_height / 12;
    cw = (bw * 5) / 4;
    t  = bw / 3;
    yb = h1 + h2;
    for (int k = 0; k < 7; k++) send_pixel(15'(bw * k), 15'd0);
    send_pixel(15'(cfg_width - 1), 15'(h1 - 1));
    send_pixel(15'h7FFF, 15'd0);
    send_pixel(15'd0, 15'(h1));
    send_pixel(15'(6 * bw), 15'(yb - 1));
    for (int k = 0; k < 4; k++) send_pixel(15'(cw * k), 15'(yb));
    send_pixel(15'(5 * bw), 15'(yb));
    send_pixel(15'(5 * bw + t), 15'(yb));
    send_pixel(15'(5 * bw + 2 * t), 15'(cfg_height - 1));
    send_pixel(15'(6 * bw), 15'(yb));
    send_pixel(15'h7FFF, 15'h7FFF);
    send_pixel(15'd0, 15'h7FFF);
    wait_for_results();
  endtask

  // All pixel formats, the undefined codes included
  task automatic test_pixel_formats();
    set_idling(0, 0);
    for (int f = 0; f < 16; f++) run_setting(random_size(), random_size(), f, 25);
  endtask

  // Extreme and degenerate frame sizes
  task automatic test_frame_sizes();
    set_idling(52, 0);
    run_setting(1, 1, $urandom_range(15), 40);
    run_setting(32767, 32767, $urandom_range(15), 40);
    run_setting(6, 480, $urandom_range(15), 40);      // zero bar width
    run_setting(14, 12, $urandom_range(15), 40);      // pluge bars collapse
    run_setting(7, 3, $urandom_range(15), 40);
    run_setting(20, 1, $urandom_range(15), 40);
    run_setting(640, 2, $urandom_range(15), 40);
    run_setting(32767, 1, $urandom_range(15), 40);
    run_setting(1, 32767, FMT_ARGB4444, 40);
  endtask

  // Random settings under each idling mix; junk above the field width is dropped
  task automatic test_random_settings();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(52, 0);
        2:       set_idling(0, 52);
        default: set_idling(12, 12);
      endcase
      repeat (4) begin
        run_setting({17'($urandom()), random_size()}, {17'($urandom()), random_size()},
                    {28'($urandom()), 4'($urandom_range(15))}, 30);
      end
    end
  endtask

  // Fill the pipeline behind a long receiver hold-off, pause until drained, then send more with random idling
  task automatic test_backpressure();
    set_idling(0, 0);
    reg_write(REG_FRAME_WIDTH, 700);
    reg_write(REG_FRAME_HEIGHT, 120);
    reg_write(REG_PIXEL_FORMAT, FMT_RGB565);
    hold_reqs <= hold_reqs + 1;
    repeat (60) send_random_pixel();
    coord_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    set_idling(12, 12);
    repeat (40) send_random_pixel();
    wait_for_results();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    coord_ch.valid   <= 1'b0;
    coord_ch.pixel_x <= '0;
    coord_ch.pixel_y <= '0;
    cfg_width        = RESET_WIDTH;
    cfg_height       = RESET_HEIGHT;
    cfg_format       = FMT_RGBA8888;
    requests_sent    = 0;
    results_checked  = 0;
    settings_written = 0;
    failures         = 0;
    hold_reqs        = 0;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_layout();
    test_pixel_formats();
    test_frame_sizes();
    test_random_settings();
    test_backpressure();

    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      failures++;
    end
    $display("Sent %0d pixel requests and checked %0d results over %0d register writes,",
             requests_sent, results_checked, settings_written);
    $display("covering all formats, degenerate frames and output backpressure.");
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
